// ===== hw/rtl/mpg_pkg.sv =====
// Package for the MINSTD polar Gaussian generator.
// Holds widths, arithmetic constants, register indexes and the sequencer states.
// Used by the result channel interface, the top level and the testbench.
package mpg_pkg;

	localparam int unsigned SAMPLE_W = 32;
	localparam int unsigned LCG_W    = 31;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [LCG_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
	localparam logic [LCG_W-1:0] RANGE_M  = 31'h7FFF_FFFE;
	localparam logic [LCG_W-1:0] LCG_SEED = 31'd1;
	localparam logic [15:0]      LCG_MUL  = 16'd48271;
	// Twice ln 2 in Q1.24.
	localparam logic [24:0]      LN2_X2   = 25'd23258160;

	localparam logic signed [SAMPLE_W-1:0] AMP_RESET  = 32'sh0001_0000;
	localparam logic signed [SAMPLE_W-1:0] MEAN_RESET = 32'sh0000_0000;
	localparam logic signed [SAMPLE_W-1:0] STD_RESET  = 32'sh0001_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AMPLITUDE   = 2'd0,
		CFG_MEAN_OFFSET = 2'd1,
		CFG_STD_DEV     = 2'd2
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_LCG_MUL, ST_LCG_RED, ST_UNI, ST_CDIV, ST_DIV, ST_DIV_END,
		ST_SQ_U, ST_SQ_V, ST_SQ_SUM, ST_NORM, ST_LOG_MUL, ST_LOG_RED,
		ST_W_MUL, ST_W_RED, ST_SQRT, ST_SCL_U_MUL, ST_SCL_U, ST_SCL_V_MUL,
		ST_SCL_V, ST_OUT_MUL1, ST_OUT_ADD, ST_OUT_MUL2, ST_OUT_SAT, ST_FIN
	} mpg_state_t;

	typedef enum logic [2:0] {
		DP_U_A, DP_U_Q, DP_V_A, DP_V_Q, DP_R
	} div_phase_t;

endpackage

// ===== hw/rtl/mpg_req_if.sv =====
// Request channel of the Gaussian generator: valid, ready and the run-end mark.
// Depends on nothing else.
interface mpg_req_if;
	logic valid;
	logic ready;
	logic last_of_run;

	modport source (output valid, output last_of_run, input ready);
	modport sink (input valid, input last_of_run, output ready);
endinterface

// ===== hw/rtl/mpg_rsp_if.sv =====
// Result channel of the Gaussian generator: valid, ready, sample and run-end echo.
// Depends on mpg_pkg for the sample width.
interface mpg_rsp_if;
	import mpg_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [SAMPLE_W-1:0]  sample;
	logic                        run_end;

	modport source (output valid, output sample, output run_end, input ready);
	modport sink (input valid, input sample, input run_end, output ready);
endinterface

// ===== hw/rtl/minstd_polar_gaussian_generator.sv =====
// Gaussian sample source: a MINSTD generator feeding a Marsaglia polar transform in
// fixed point, scaled as ((z * std_dev) + mean_offset) * amplitude in signed Q16.16.
// Depends on mpg_pkg, mpg_req_if and mpg_rsp_if.
//
// Samples come in pairs. A request served from the cached half of a pair goes
// straight to the output scaling. A request that needs a fresh pair runs polar trials
// (4 LCG draws, each a multiply and a reduction, 4 quotients by the constant 2^31-2,
// and 3 squaring steps), about 1.27 trials on average, then normalize, a 30-step log,
// one bit-serial division, a 32-step square root and scaling. The bit-serial divider
// shares one compare-subtract unit with the square root; all products go through
// one registered multiplier. A request is accepted only while the sequencer is idle,
// but a finished sample waits in an output register, so the next request can be
// taken before the previous sample is collected. A set last_of_run reseeds the
// generator and drops the cached half after that sample.
module minstd_polar_gaussian_generator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mpg_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [mpg_pkg::SAMPLE_W-1:0]     cfg_wdata,
	mpg_req_if.sink                          req,
	mpg_rsp_if.source                        rsp
);
	import mpg_pkg::*;

	logic signed [31:0] amp_q, mean_q, std_q;
	mpg_state_t         state_q, state_d;
	div_phase_t         dph_q;

	logic [30:0]        lcg_q;
	logic [30:0]        drw_q [4];
	logic [1:0]         k_q;
	logic signed [31:0] cache_q;
	logic               cvalid_q;
	logic               last_q;

	logic signed [31:0] u_q, v_q, z_q;
	logic [63:0]        s_q, num_q, root_q, bit_q;
	logic [31:0]        rem_q, quo_q;
	logic [30:0]        dvs_q, y_q, t_q;
	logic [29:0]        frac_q;
	logic [5:0]         n_q, cnt_q;

	logic signed [37:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [70:0] mul_p, prod_q;

	logic signed [31:0] sample_q;
	logic               run_end_q, ovalid_q;

	logic               accept_in, out_free;
	logic [31:0]        lsum;
	logic [30:0]        lcg_nx;
	logic [32:0]        cand;
	logic [64:0]        sub_a, sub_b, diff;
	logic               sub_ge;
	logic [63:0]        ssum, rr, x0;
	logic               reject;
	logic [31:0]        tt;
	logic [35:0]        big_l;
	logic [36:0]        w;
	logic [5:0]         sh;
	logic [31:0]        umag, vmag;
	logic               cdiv_hit;

	function automatic logic [30:0] lo_off(input logic [30:0] x);
		logic [30:0] t;
		t = x - 31'd1;
		if (t >= RANGE_M)
			t = RANGE_M - 31'd1;
		return t;
	endfunction

	function automatic logic signed [31:0] sat_q16(input logic signed [70:0] p);
		logic signed [70:0] f;
		f = p >>> 16;
		if (f > 71'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (f < -71'sd2147483648)
			return 32'sh8000_0000;
		else
			return f[31:0];
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31])
			return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			return s[31:0];
	endfunction

	// Magnitude times root, shifted down, then the sign goes back on with saturation.
	function automatic logic signed [31:0] scale_out(input logic [61:0] p,
			input logic [5:0] s, input logic neg);
		logic [61:0] zz;
		zz = p >> s;
		if (neg) begin
			if (zz > 62'd2147483648)
				return 32'sh8000_0000;
			else
				return signed'(32'd0 - zz[31:0]);
		end else begin
			if (zz > 62'd2147483647)
				return 32'sh7FFF_FFFF;
			else
				return signed'(zz[31:0]);
		end
	endfunction

	assign accept_in = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free  = !ovalid_q || rsp.ready;

	assign rsp.valid   = ovalid_q;
	assign rsp.sample  = sample_q;
	assign rsp.run_end = run_end_q;

	// Modulus 2^31-1: fold the high part onto the low part, one correction.
	assign lsum   = {1'b0, prod_q[30:0]} + {16'b0, prod_q[46:31]};
	assign lcg_nx = (lsum >= {1'b0, LCG_MOD}) ? 31'(lsum - {1'b0, LCG_MOD}) : lsum[30:0];

	// Once the folded value is below 2^30, only 2^30-1 itself still holds one divisor.
	assign cdiv_hit = (num_q[29:0] == 30'h3FFF_FFFF);

	assign cand   = {rem_q, num_q[63]};
	assign diff   = sub_a - sub_b;
	assign sub_ge = !diff[64];

	assign ssum   = s_q + prod_q[63:0];
	assign reject = (ssum == 64'd0) || (ssum[63:62] != 2'b00);
	assign tt     = prod_q[61:30];
	assign big_l  = {n_q, 30'b0} - {6'b0, frac_q};
	assign w      = prod_q[60:24];
	assign rr     = n_q[0] ? {num_q[62:0], 1'b0} : num_q;
	assign x0     = {rr[37:0], 26'b0};
	assign sh     = 6'd41 - {1'b0, n_q[5:1]};
	assign umag   = u_q[31] ? (32'd0 - $unsigned(u_q)) : $unsigned(u_q);
	assign vmag   = v_q[31] ? (32'd0 - $unsigned(v_q)) : $unsigned(v_q);

	// The shared compare-subtract unit: division steps and square-root steps.
	always_comb begin
		sub_a = '0;
		sub_b = '0;
		unique case (state_q)
			ST_DIV: begin
				sub_a = {32'b0, cand};
				sub_b = {34'b0, dvs_q};
			end
			ST_SQRT: begin
				sub_a = {1'b0, num_q};
				sub_b = {1'b0, root_q + bit_q};
			end
			default: ;
		endcase
	end

	// The shared multiplier; its product is registered in prod_q every cycle.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_LCG_MUL: begin
				mul_a = {7'b0, lcg_q};
				mul_b = {17'b0, LCG_MUL};
			end
			ST_SQ_U: begin
				mul_a = {{6{u_q[31]}}, u_q};
				mul_b = {u_q[31], u_q};
			end
			ST_SQ_V: begin
				mul_a = {{6{v_q[31]}}, v_q};
				mul_b = {v_q[31], v_q};
			end
			ST_LOG_MUL: begin
				mul_a = {7'b0, t_q};
				mul_b = {2'b0, t_q};
			end
			ST_W_MUL: begin
				mul_a = {2'b0, big_l};
				mul_b = {8'b0, LN2_X2};
			end
			ST_SCL_U_MUL: begin
				mul_a = {7'b0, root_q[30:0]};
				mul_b = {1'b0, umag};
			end
			ST_SCL_V_MUL: begin
				mul_a = {7'b0, root_q[30:0]};
				mul_b = {1'b0, vmag};
			end
			ST_OUT_MUL1: begin
				mul_a = {{6{z_q[31]}}, z_q};
				mul_b = {std_q[31], std_q};
			end
			ST_OUT_MUL2: begin
				mul_a = {{6{z_q[31]}}, z_q};
				mul_b = {amp_q[31], amp_q};
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (accept_in) state_d = cvalid_q ? ST_OUT_MUL1 : ST_LCG_MUL;
			ST_LCG_MUL:   state_d = ST_LCG_RED;
			ST_LCG_RED:   state_d = (k_q == 2'd3) ? ST_UNI : ST_LCG_MUL;
			ST_UNI:       state_d = ST_CDIV;
			ST_CDIV:      if (num_q[63:30] == 34'd0) state_d = ST_DIV_END;
			ST_DIV:       if (cnt_q == 6'd63) state_d = ST_DIV_END;
			ST_DIV_END: begin
				unique case (dph_q)
					DP_V_Q:  state_d = ST_SQ_U;
					DP_R:    state_d = ST_SQRT;
					default: state_d = ST_CDIV;
				endcase
			end
			ST_SQ_U:      state_d = ST_SQ_V;
			ST_SQ_V:      state_d = ST_SQ_SUM;
			ST_SQ_SUM:    state_d = reject ? ST_LCG_MUL : ST_NORM;
			ST_NORM:      if (s_q[61]) state_d = ST_LOG_MUL;
			ST_LOG_MUL:   state_d = ST_LOG_RED;
			ST_LOG_RED:   state_d = (cnt_q == 6'd29) ? ST_W_MUL : ST_LOG_MUL;
			ST_W_MUL:     state_d = ST_W_RED;
			ST_W_RED:     state_d = ST_DIV;
			ST_SQRT:      if (cnt_q == 6'd31) state_d = ST_SCL_U_MUL;
			ST_SCL_U_MUL: state_d = ST_SCL_U;
			ST_SCL_U:     state_d = ST_SCL_V_MUL;
			ST_SCL_V_MUL: state_d = ST_SCL_V;
			ST_SCL_V:     state_d = ST_OUT_MUL1;
			ST_OUT_MUL1:  state_d = ST_OUT_ADD;
			ST_OUT_ADD:   state_d = ST_OUT_MUL2;
			ST_OUT_MUL2:  state_d = ST_OUT_SAT;
			ST_OUT_SAT:   state_d = ST_FIN;
			ST_FIN:       if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Control state, generator state, configuration and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			amp_q     <= AMP_RESET;
			mean_q    <= MEAN_RESET;
			std_q     <= STD_RESET;
			lcg_q     <= LCG_SEED;
			cache_q   <= '0;
			cvalid_q  <= 1'b0;
			ovalid_q  <= 1'b0;
			sample_q  <= '0;
			run_end_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_AMPLITUDE:   amp_q  <= cfg_wdata;
					CFG_MEAN_OFFSET: mean_q <= cfg_wdata;
					CFG_STD_DEV:     std_q  <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == ST_LCG_RED)
				lcg_q <= lcg_nx;
			if (state_q == ST_IDLE && accept_in && cvalid_q)
				cvalid_q <= 1'b0;
			if (state_q == ST_SCL_U) begin
				cache_q  <= scale_out(prod_q[61:0], sh, u_q[31]);
				cvalid_q <= 1'b1;
			end
			if (state_q == ST_FIN && out_free) begin
				ovalid_q  <= 1'b1;
				sample_q  <= z_q;
				run_end_q <= last_q;
				if (last_q) begin
					lcg_q    <= LCG_SEED;
					cache_q  <= '0;
					cvalid_q <= 1'b0;
				end
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		unique case (state_q)
			ST_IDLE: begin
				k_q <= 2'd0;
				if (accept_in) begin
					last_q <= req.last_of_run;
					z_q    <= cache_q;
				end
			end
			ST_LCG_RED: begin
				drw_q[k_q] <= lcg_nx;
				k_q        <= k_q + 2'd1;
			end
			ST_UNI: begin
				// Dividends by 2^31-2 are held halved and then divided by 2^30-1.
				num_q <= {2'b0, lo_off(drw_q[0]), 31'b0};
				rem_q <= '0;
				cnt_q <= '0;
				quo_q <= '0;
				dph_q <= DP_U_A;
			end
			ST_CDIV: begin
				// x = hi * 2^30 + lo = hi * (2^30-1) + (hi + lo).
				if (num_q[63:30] != 34'd0) begin
					num_q <= {30'b0, num_q[63:30]} + {34'b0, num_q[29:0]};
					quo_q <= quo_q + num_q[61:30];
				end else begin
					num_q <= {32'b0, quo_q + {31'b0, cdiv_hit}};
				end
			end
			ST_DIV: begin
				num_q <= {num_q[62:0], sub_ge};
				rem_q <= sub_ge ? diff[31:0] : cand[31:0];
				cnt_q <= cnt_q + 6'd1;
			end
			ST_DIV_END: begin
				rem_q <= '0;
				cnt_q <= '0;
				quo_q <= '0;
				unique case (dph_q)
					DP_U_A: begin
						num_q <= {2'b0, lo_off(drw_q[3]), 31'b0} + {33'b0, num_q[31:1]};
						dph_q <= DP_U_Q;
					end
					DP_U_Q: begin
						u_q   <= {~num_q[31], num_q[30:0]};
						num_q <= {2'b0, lo_off(drw_q[2]), 31'b0};
						dph_q <= DP_V_A;
					end
					DP_V_A: begin
						num_q <= {2'b0, lo_off(drw_q[1]), 31'b0} + {33'b0, num_q[31:1]};
						dph_q <= DP_V_Q;
					end
					DP_V_Q: begin
						v_q <= {~num_q[31], num_q[30:0]};
					end
					DP_R: begin
						num_q  <= x0;
						root_q <= '0;
						bit_q  <= 64'h4000_0000_0000_0000;
					end
					default: ;
				endcase
			end
			ST_SQ_V: s_q <= prod_q[63:0];
			ST_SQ_SUM: begin
				k_q <= 2'd0;
				s_q <= ssum;
				n_q <= 6'd1;
			end
			ST_NORM: begin
				if (s_q[61:46] == 16'd0) begin
					s_q <= {s_q[47:0], 16'b0};
					n_q <= n_q + 6'd16;
				end else if (!s_q[61]) begin
					s_q <= {s_q[62:0], 1'b0};
					n_q <= n_q + 6'd1;
				end else begin
					y_q    <= s_q[61:31];
					t_q    <= s_q[61:31];
					cnt_q  <= '0;
					frac_q <= '0;
				end
			end
			ST_LOG_RED: begin
				// A square at or above 2 gives the next fraction bit of log2.
				t_q    <= tt[31] ? tt[31:1] : tt[30:0];
				frac_q <= {frac_q[28:0], tt[31]};
				cnt_q  <= cnt_q + 6'd1;
			end
			ST_W_RED: begin
				num_q <= {1'b0, w, 26'b0};
				dvs_q <= y_q;
				rem_q <= '0;
				cnt_q <= '0;
				dph_q <= DP_R;
			end
			ST_SQRT: begin
				if (sub_ge) begin
					num_q  <= diff[63:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 6'd1;
			end
			ST_SCL_V:   z_q <= scale_out(prod_q[61:0], sh, v_q[31]);
			ST_OUT_ADD: z_q <= sat_add(sat_q16(prod_q), mean_q);
			ST_OUT_SAT: z_q <= sat_q16(prod_q);
			default: ;
		endcase
	end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the MINSTD polar Gaussian generator.
// It predicts each sample in fixed point and compares it with the block's output.
// Depends on mpg_pkg, mpg_req_if, mpg_rsp_if and minstd_polar_gaussian_generator.
`timescale 1ns / 1ps

class gauss_scoreboard;
	typedef struct {
		logic signed [31:0] sample;
		logic               run_end;
	} gauss_result_t;

	localparam longint unsigned MINSTD_MUL = 64'd48271;
	localparam longint unsigned MINSTD_MOD = 64'd2147483647;
	localparam longint unsigned UNI_RANGE  = 64'd2147483646;
	localparam longint unsigned LN2_Q24    = 64'd11629080;

	int amp_q16;
	int mean_q16;
	int std_q16;
	longint unsigned seed_state;
	int held_normal;
	bit held_valid;
	gauss_result_t expected_samples[$];
	int errors;

	function new();
		amp_q16 = 32'sh0001_0000;
		mean_q16 = 0;
		std_q16 = 32'sh0001_0000;
		seed_state = 1;
		held_normal = 0;
		held_valid = 0;
		errors = 0;
	endfunction

	function void set_reg(mpg_pkg::cfg_idx_t idx, int value);
		case (idx)
			mpg_pkg::CFG_AMPLITUDE: amp_q16 = value;
			mpg_pkg::CFG_MEAN_OFFSET: mean_q16 = value;
			mpg_pkg::CFG_STD_DEV: std_q16 = value;
			default: ;
		endcase
	endfunction

	function int pending();
		return expected_samples.size();
	endfunction

	function int clamp32(longint x);
		if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (x < -64'sd2147483648) return 32'sh8000_0000;
		return int'(x);
	endfunction

	// Arithmetic shift gives floor division by 2^16.
	function int q16_mul(int a, int b);
		longint prod;
		prod = longint'(a) * longint'(b);
		return clamp32(prod >>> 16);
	endfunction

	function longint unsigned next_draw();
		seed_state = (seed_state * MINSTD_MUL) % MINSTD_MOD;
		return seed_state;
	endfunction

	function longint uniform_q31(longint unsigned lo, longint unsigned hi);
		longint unsigned l, h, a, q;
		l = (lo - 1) & 64'h7FFF_FFFF;
		h = (hi - 1) & 64'h7FFF_FFFF;
		if (l >= UNI_RANGE) l = UNI_RANGE - 1;
		if (h >= UNI_RANGE) h = UNI_RANGE - 1;
		a = (l << 32) / UNI_RANGE;
		q = ((h << 32) + a) / UNI_RANGE;
		return longint'(q) - 64'sh8000_0000;
	endfunction

	function longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function int apply_factor(longint x, longint unsigned sq, int unsigned h);
		longint unsigned mag, z;
		mag = (x < 0) ? longint'(-x) : x;
		z = (mag * sq) >> (41 - h);
		if (x < 0) begin
			if (z > 64'h8000_0000) z = 64'h8000_0000;
			return clamp32(-longint'(z));
		end
		if (z > 64'h7FFF_FFFF) z = 64'h7FFF_FFFF;
		return int'(z);
	endfunction

	function int polar_pair();
		longint u, v;
		longint unsigned s, y, frac, big_l, w, r, sq, t;
		longint unsigned a, b, c, d;
		int unsigned p, n, h;
		frac = 0;
		p = 0;
		forever begin
			a = next_draw();
			b = next_draw();
			c = next_draw();
			d = next_draw();
			u = uniform_q31(a, d);
			v = uniform_q31(c, b);
			s = longint'(u * u) + longint'(v * v);
			if (s != 0 && s < (64'd1 << 62)) break;
		end
		for (int i = 0; i < 62; i++)
			if (s[i]) p = i;
		n = 62 - p;
		y = (p >= 30) ? (s >> (p - 30)) : (s << (30 - p));
		// Repeated squaring yields log2 of the mantissa one bit at a time.
		t = y;
		for (int i = 0; i < 30; i++) begin
			t = (t * t) >> 30;
			if (t >= (64'd1 << 31)) begin
				t >>= 1;
				frac |= 64'd1 << (29 - i);
			end
		end
		big_l = (longint'(n) << 30) - frac;
		w = (2 * big_l * LN2_Q24) >> 24;
		r = (w << 26) / y;
		if (n[0]) r <<= 1;
		sq = int_sqrt(r << 26);
		h = n >> 1;
		held_normal = apply_factor(u, sq, h);
		held_valid = 1;
		return apply_factor(v, sq, h);
	endfunction

	function void note_request(logic last);
		int z, y;
		gauss_result_t res;
		if (held_valid) begin
			z = held_normal;
			held_valid = 0;
		end else begin
			z = polar_pair();
		end
		y = q16_mul(z, std_q16);
		y = clamp32(longint'(y) + longint'(mean_q16));
		y = q16_mul(y, amp_q16);
		if (last) begin
			seed_state = 1;
			held_normal = 0;
			held_valid = 0;
		end
		res.sample = y;
		res.run_end = last;
		expected_samples.push_back(res);
	endfunction

	function void check_result(logic signed [31:0] sample, logic run_end);
		gauss_result_t exp_res;
		if (expected_samples.size() == 0) begin
			$error("unexpected sample %0d", sample);
			errors++;
			return;
		end
		exp_res = expected_samples.pop_front();
		if (sample !== exp_res.sample) begin
			$error("sample: expected %0d, got %0d", exp_res.sample, sample);
			errors++;
		end
		if (run_end !== exp_res.run_end) begin
			$error("run_end: expected %0d, got %0d", exp_res.run_end, run_end);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import mpg_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [SAMPLE_W-1:0] cfg_wdata;
	bit quiet;
	int hold_cycles;
	int stall_cycles;
	gauss_scoreboard sb;

	mpg_req_if req_ch ();
	mpg_rsp_if rsp_ch ();

	minstd_polar_gaussian_generator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb_top: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) sb.note_request(req_ch.last_of_run);
		if (arst_n && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.sample, rsp_ch.run_end);
	end

	// Result side: random stall bursts, plus one long hold-off on request.
	initial begin
		stall_cycles = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) hold_cycles--;
			else if (stall_cycles > 0) stall_cycles--;
			else if (!quiet && $urandom_range(0, 5) == 0) stall_cycles = $urandom_range(1, 8);
			rsp_ch.ready <= (hold_cycles == 0 && stall_cycles == 0);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		if (idx != CFG_UNUSED) sb.set_reg(cfg_idx_t'(idx), value);
	endtask

	task automatic set_config(int amp, int mean, int std);
		write_reg(CFG_AMPLITUDE, amp);
		write_reg(CFG_MEAN_OFFSET, mean);
		write_reg(CFG_STD_DEV, std);
		cfg_we <= 1'b0;
	endtask

	task automatic send_request(logic last);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.last_of_run <= last;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// One more edge first, so the last accepted transaction is surely noted.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic random_requests(int count);
		repeat (count) send_request($urandom_range(0, 15) == 0);
	endtask

	initial begin
		sb = new();
		quiet = 0;
		hold_cycles = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = CFG_AMPLITUDE;
		cfg_wdata = '0;
		req_ch.valid = 0;
		req_ch.last_of_run = 0;
		rsp_ch.ready = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: run end on a fresh pair, on a cached half, and back to back.
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b1);
		send_request(1'b0);
		drain();

		// Saturating extremes, then the opposite extremes, then all zero.
		set_config(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		repeat (5) send_request(1'b0);
		drain();
		set_config(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
		repeat (5) send_request(1'b0);
		drain();
		set_config(0, 0, 0);
		send_request(1'b0);
		send_request(1'b1);
		drain();
		// Writes to the unused index must leave every register alone.
		set_config(32'sh0002_0000, -32'sh0000_8000, -32'sh0001_8000);
		write_reg(CFG_UNUSED, $urandom);
		cfg_we <= 1'b0;
		repeat (5) send_request(1'b0);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 3)
				set_config($urandom, $urandom, $urandom);
			else
				set_config($urandom_range(0, 32'h0004_0000) - 32'sh0002_0000,
					$urandom_range(0, 32'h0002_0000) - 32'sh0001_0000,
					$urandom_range(0, 32'h0008_0000) - 32'sh0004_0000);
			if (ph == 1) hold_cycles = 400;
			if (ph == 4) quiet = 1;
			random_requests(255);
			drain();
		end

		if (sb.errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule
